// File: hdl/oie_pkg.sv
// Shared types and constants for the operate-instruction execution unit.
// No dependencies; imported by oie_exec and operate_instruction_exec_unit.
`default_nettype none

package oie_pkg;

  localparam int unsigned DataW   = 18;
  localparam int unsigned AccW    = DataW + 1;
  localparam int unsigned OpW     = 15;
  localparam int unsigned IrqNumW = 6;

  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 80;

  localparam logic [IrqNumW-1:0] IrqNumReset = '0;

  // Field select of group 0, bits 3..1
  typedef enum logic [2:0] {
    G0_NOP  = 3'd0,
    G0_SWAP = 3'd1,
    G0_RL1  = 3'd2,
    G0_RL2  = 3'd3,
    G0_RR1  = 3'd4,
    G0_RR2  = 3'd5,
    G0_TOXA = 3'd6,
    G0_TOXB = 3'd7
  } g0_sel_t;

  // Architectural state visible to the execute stage
  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [DataW-1:0] pc;
    logic [DataW-1:0] xa;
    logic [DataW-1:0] xb;
    logic [DataW-1:0] stop;
    logic             ie;
    logic             run;
  } oie_state_t;

  // Instruction beat as held in the input register
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           no_l1;
    logic           above1;
  } oie_instr_t;

endpackage : oie_pkg

`default_nettype wire

// File: hdl/oie_exec.sv
// Single-pass execute logic for one operate instruction.
// Depends on oie_pkg; instantiated by operate_instruction_exec_unit.
`default_nettype none

module oie_exec (
  input  oie_pkg::oie_instr_t instr,
  input  oie_pkg::oie_state_t cur,
  output oie_pkg::oie_state_t nxt,
  output logic                irq_req
);
  import oie_pkg::*;

  logic [OpW-1:0]   op;
  logic [AccW-1:0]  a0;
  logic [AccW-1:0]  g0_acc;
  logic [DataW-1:0] g0_xa;
  logic [DataW-1:0] g0_xb;
  logic             g1_cond;
  logic             g3_cond;
  logic             g3_ie;
  logic             halt_ok_g1;
  logic             halt_ok_g3;
  logic             skip;
  g0_sel_t          sel;

  assign op  = instr.op;
  assign sel = g0_sel_t'(op[3:1]);

  // Group 0: clear, complement, then one shift/swap/move. Increment needs bit 0,
  // which selects group 3, so it never applies here.
  always_comb begin
    a0 = cur.acc;
    if (op[7]) a0[DataW-1:0] = '0;
    if (op[6]) a0[DataW]     = 1'b0;
    if (op[5]) a0[DataW-1:0] = ~a0[DataW-1:0];
    if (op[4]) a0[DataW]     = ~a0[DataW];
    g0_acc = a0;
    g0_xa  = cur.xa;
    g0_xb  = cur.xb;
    unique case (sel)
      G0_SWAP: g0_acc = {a0[18], a0[8:0], a0[17:9]};
      G0_RL1:  g0_acc = {a0[17:0], a0[18]};
      G0_RL2:  g0_acc = {a0[16:0], a0[18:17]};
      G0_RR1:  g0_acc = {a0[0], a0[18:1]};
      G0_RR2:  g0_acc = {a0[1:0], a0[18:2]};
      G0_TOXA: g0_xa  = a0[DataW-1:0];
      G0_TOXB: g0_xb  = a0[DataW-1:0];
      G0_NOP:  g0_acc = a0;
      default: g0_acc = a0;
    endcase
  end

  // Group 1 skip tests look at the accumulator before this instruction
  assign g1_cond = ((op[6] && cur.acc[17]) ||
                    (op[5] && (cur.acc[DataW-1:0] == '0)) ||
                    (op[4] && !cur.acc[DataW])) ^ op[3];
  assign halt_ok_g1 = instr.above1 || !cur.ie;

  // Group 3: the interrupt-enable update comes before halt and skip tests
  assign g3_ie      = (op[7] ? 1'b0 : cur.ie) ^ op[5];
  assign halt_ok_g3 = instr.above1 || !g3_ie;
  assign g3_cond    = ((op[4] && g3_ie) || (op[6] && instr.no_l1)) ^ op[8];

  always_comb begin
    nxt     = cur;
    irq_req = 1'b0;
    skip    = 1'b0;
    priority if (op[0]) begin
      nxt.ie = g3_ie;
      if (op[2]) nxt.stop = cur.acc[DataW-1:0];
      irq_req = op[3];
      if (op[1] && halt_ok_g3) nxt.run = 1'b0;
      skip = g3_cond;
    end else if (op[8]) begin
      skip = g1_cond;
      if (op[7]) nxt.acc[DataW-1:0] = '0;
      if (op[1] && halt_ok_g1) nxt.run = 1'b0;
      if (op[2]) nxt.acc[DataW-1:0] = nxt.acc[DataW-1:0] | cur.stop;
    end else begin
      nxt.acc = g0_acc;
      nxt.xa  = g0_xa;
      nxt.xb  = g0_xb;
    end
    nxt.pc = cur.pc + (skip ? DataW'(2) : DataW'(1));
  end

endmodule : oie_exec

`default_nettype wire

// File: hdl/operate_instruction_exec_unit.sv
// Top level of the operate-instruction execution unit: input register,
// architectural state, result register. Depends on oie_pkg and oie_exec.
//
// Usage:
//   in_*   : one beat per operate instruction (low 15 opcode bits plus two
//            interrupt status flags). Accepted when in_tvalid && in_tready.
//   out_*  : one beat per instruction with the full register image after it
//            executes (accumulator with link, PC, both index registers,
//            interrupt enable, halted, host interrupt request pulse).
//   cfg_*  : write of the host interrupt line number; always ready.
// An input beat is held in the input register, then executes into the result
// register. Throughput is one instruction per cycle while out_tready is high;
// the execute stage and its state update are a single combinational pass per
// cycle, so each beat sees the state left by the one before it.
// When out_tready is low the result register holds; the input register
// then fills and in_tready drops until the result is taken.
// Reset clears the architectural state, loads IRQ_NUM_RESET into the line number,
// leaves the processor running, and empties both stages.
`default_nettype none

module operate_instruction_exec_unit #(
  parameter int unsigned IRQ_NUM_RESET = oie_pkg::IrqNumReset
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // [14:0] op_bits, [15] no_level1_pending, [16] lowest_pending_above1
  input  wire logic [oie_pkg::InTdataW-1:0]   in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [18:0] acc_out, [36:19] pc_out, [54:37] index_a_out, [72:55] index_b_out,
  // [73] int_enable_out, [74] halted, [75] irq_request
  output logic [oie_pkg::OutTdataW-1:0]       out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [oie_pkg::IrqNumW-1:0]    cfg_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready
);
  import oie_pkg::*;

  oie_instr_t         instr_r;
  logic               s1_valid_r;
  oie_state_t         st_r;
  oie_state_t         st_nxt;
  logic               irq_nxt;
  logic               out_valid_r;
  logic [OutTdataW-1:0] out_data_r;
  logic [OutTdataW-1:0] out_data_nxt;
  logic [IrqNumW-1:0] irq_num_r;
  logic               fire;

  // Execute when the result register is free or drains this cycle
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign cfg_ready = 1'b1;

  oie_exec u_exec (
    .instr   (instr_r),
    .cur     (st_r),
    .nxt     (st_nxt),
    .irq_req (irq_nxt)
  );

  assign out_data_nxt = {{(OutTdataW - 76){1'b0}}, irq_nxt, !st_nxt.run, st_nxt.ie,
                         st_nxt.xb, st_nxt.xa, st_nxt.pc, st_nxt.acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{acc: '0, pc: '0, xa: '0, xb: '0, stop: '0, ie: 1'b0, run: 1'b1};
      irq_num_r   <= IrqNumW'(IRQ_NUM_RESET);
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        irq_num_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      instr_r <= '{op: in_tdata[OpW-1:0], no_l1: in_tdata[OpW], above1: in_tdata[OpW+1]};
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // Once halted, the run flag stays clear until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.run |=> !st_r.run)
    else $error("run flag set again without reset");

  // Each executed instruction advances the PC by one or two
  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (st_r.pc == $past(st_r.pc) + DataW'(1)) ||
             (st_r.pc == $past(st_r.pc) + DataW'(2)))
    else $error("PC step out of range");

  // State only moves when an instruction executes
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(st_r))
    else $error("state changed without an instruction");

  // Interrupt request only from group 3 with its request bit
  a_irq_src: assert property (@(posedge clk) disable iff (!rst_n)
    fire && irq_nxt |-> instr_r.op[0] && instr_r.op[3])
    else $error("spurious interrupt request");

  // Interrupt line number follows the last write
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> irq_num_r == $past(cfg_data))
    else $error("interrupt line number not written");

endmodule : operate_instruction_exec_unit

`default_nettype wire
